[hw/rtl/tsft_pkg.sv]
package tsft_pkg;

  localparam int unsigned StampBits = 48;
  localparam int unsigned OpBits    = 3;

  localparam logic [OpBits-1:0] OpInsert  = 3'd0;
  localparam logic [OpBits-1:0] OpShow    = 3'd1;
  localparam logic [OpBits-1:0] OpCheck   = 3'd2;
  localparam logic [OpBits-1:0] OpTrim    = 3'd3;
  localparam logic [OpBits-1:0] OpClear   = 3'd4;
  localparam logic [OpBits-1:0] OpAdvance = 3'd5;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StDup   = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  localparam logic [1:0] CfgBack     = 2'd0;
  localparam logic [1:0] CfgForward  = 2'd1;
  localparam logic [1:0] CfgTol      = 2'd2;
  localparam logic [1:0] CfgDuration = 2'd3;

  typedef struct packed {
    logic [OpBits-1:0]    op;
    logic [StampBits-1:0] time_value;
  } req_t;

  typedef struct packed {
    logic [5:0] entry_index;
    logic       found;
    logic       changed;
    logic [1:0] status;
    logic [6:0] entry_count;
  } rsp_t;

endpackage

[hw/rtl/tsft_ram.sv]
module tsft_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/timestamp_sorted_frame_table_unit.sv]
// Sorted timestamp table held in one dual-port RAM (one write and one registered read
// per cycle). Every request other than clear, the unused codes and empty-table cases walks
// the table one entry per cycle through that read port: insert scans for its place and
// then shifts the upper entries up one by one, show, check and advance scan all entries
// for the nearest, trim scans the low end and then the high end, and any low-end drop that
// leaves survivors is followed by a copy pass moving them down. The next request is taken
// once the unit is back in idle and the result register is free. Only read data from
// entries below the fill count is used.
module timestamp_sorted_frame_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  tsft_pkg::req_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output tsft_pkg::rsp_t                       out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_index_i,
  input  logic [tsft_pkg::StampBits-1:0]       cfg_data_i
);

  localparam int unsigned Aw = $clog2(TABLE_DEPTH);
  localparam int unsigned Cw = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned Sw = tsft_pkg::StampBits;
  localparam logic [Cw-1:0] FullCount = Cw'(TABLE_DEPTH);

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SScan  = 8'b00000010,
    SShift = 8'b00000100,
    SNear  = 8'b00001000,
    STrimL = 8'b00010000,
    SCopy  = 8'b00100000,
    STrimH = 8'b01000000,
    SDone  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [Sw-1:0] back_q, fwd_q, tol_q, dur_q;
  logic [Cw-1:0] count_q, count_d;
  logic [Sw-1:0] cur_time_q, cur_time_d;
  logic [Aw-1:0] cur_idx_q, cur_idx_d;
  logic          cur_vld_q, cur_vld_d;
  logic [2:0]    op_q, op_d;
  logic [Sw-1:0] key_q, key_d;
  logic [Cw-1:0] ptr_q, ptr_d;     // scan address issued last cycle, else fill slot or count
  logic          rd_vld_q, rd_vld_d;
  logic [Cw-1:0] pos_q, pos_d;     // insert place, drop count
  logic [Sw-1:0] best_gap_q, best_gap_d;
  logic [Aw-1:0] best_q, best_d;
  logic [Sw-1:0] best_val_q, best_val_d;
  logic          ovalid_q, ovalid_d;
  tsft_pkg::rsp_t odata_q, odata_d;

  logic          we;
  logic [Aw-1:0] waddr, raddr;
  logic [Sw-1:0] wdata, rdata;

  tsft_ram #(.Width(Sw), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_stall_o  = (state_q != SIdle) || ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  logic [Sw-1:0] gap;
  logic [Sw:0]   lo_sum, hi_sum, adv_sum;
  assign gap     = (rdata > key_q) ? rdata - key_q : key_q - rdata;
  assign lo_sum  = {1'b0, rdata} + {1'b0, back_q};
  assign hi_sum  = {1'b0, cur_time_q} + {1'b0, fwd_q};
  assign adv_sum = {1'b0, cur_time_q} + {1'b0, in_data_i.time_value};

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cur_time_d = cur_time_q;
    cur_idx_d  = cur_idx_q;
    cur_vld_d  = cur_vld_q;
    op_d       = op_q;
    key_d      = key_q;
    ptr_d      = ptr_q;
    rd_vld_d   = 1'b0;
    pos_d      = pos_q;
    best_gap_d = best_gap_q;
    best_d     = best_q;
    best_val_d = best_val_q;
    ovalid_d   = ovalid_q && out_stall_i;
    odata_d    = odata_q;
    we         = 1'b0;
    waddr      = Aw'(ptr_q);
    wdata      = rdata;
    raddr      = Aw'(ptr_q);
    case (state_q)
      SIdle: begin
        if (in_valid_i && !in_stall_o) begin
          op_d    = in_data_i.op;
          key_d   = in_data_i.time_value;
          odata_d = '0;
          ptr_d   = '0;
          pos_d   = '0;
          raddr   = '0;
          rd_vld_d = count_q != '0;
          state_d = SDone;
          case (in_data_i.op)
            tsft_pkg::OpInsert: state_d = SScan;
            tsft_pkg::OpShow, tsft_pkg::OpCheck: begin
              if (count_q == '0) odata_d.status = tsft_pkg::StEmpty;
              else state_d = SNear;
            end
            tsft_pkg::OpAdvance: begin
              if (count_q == '0) begin
                odata_d.status = tsft_pkg::StEmpty;
              end else begin
                key_d = (adv_sum > {1'b0, dur_q}) ? '0 : adv_sum[Sw-1:0];
                cur_time_d = key_d;
                state_d = SNear;
              end
            end
            tsft_pkg::OpTrim: state_d = STrimL;
            tsft_pkg::OpClear: count_d = '0;
            default: ;
          endcase
        end
      end
      SScan: begin
        // rdata holds entry ptr_q when rd_vld_q.
        if (rd_vld_q && rdata < key_q) begin
          ptr_d = ptr_q + 1'b1;
          raddr = Aw'(ptr_d);
          rd_vld_d = ptr_d < count_q;
        end else if (rd_vld_q && rdata == key_q) begin
          odata_d.status = tsft_pkg::StDup;
          state_d = SDone;
        end else if (count_q == FullCount) begin
          odata_d.status = tsft_pkg::StFull;
          state_d = SDone;
        end else begin
          pos_d = ptr_q;
          ptr_d = count_q;
          if (count_q != ptr_q) begin
            raddr = Aw'(count_q - 1'b1);
            rd_vld_d = 1'b1;
          end
          state_d = SShift;
        end
      end
      SShift: begin
        // ptr_q is the slot being filled; rdata is entry ptr_q-1.
        we = 1'b1;
        if (ptr_q == pos_q) begin
          wdata   = key_q;
          count_d = count_q + 1'b1;
          state_d = SDone;
        end else begin
          ptr_d = ptr_q - 1'b1;
          if (ptr_d != pos_q) begin
            raddr = Aw'(ptr_d - 1'b1);
            rd_vld_d = 1'b1;
          end
        end
      end
      SNear: begin
        if (rd_vld_q) begin
          if (ptr_q == '0 || gap < best_gap_q) begin
            best_gap_d = gap;
            best_d     = Aw'(ptr_q);
            best_val_d = rdata;
          end
          ptr_d = ptr_q + 1'b1;
          raddr = Aw'(ptr_d);
          rd_vld_d = ptr_d < count_q;
        end else begin
          odata_d.entry_index = 6'(best_q);
          odata_d.found = 1'b1;
          if (op_q == tsft_pkg::OpCheck) begin
            odata_d.found = best_gap_q <= tol_q;
          end else if (!(cur_vld_q && cur_idx_q == best_q)) begin
            odata_d.changed = 1'b1;
            cur_idx_d  = best_q;
            cur_vld_d  = 1'b1;
            cur_time_d = best_val_q;
          end
          state_d = SDone;
        end
      end
      STrimL: begin
        if (rd_vld_q && lo_sum < {1'b0, cur_time_q}) begin
          ptr_d = ptr_q + 1'b1;
          raddr = Aw'(ptr_d);
          rd_vld_d = ptr_d < count_q;
        end else begin
          pos_d = ptr_q;
          count_d = count_q - ptr_q;
          if (ptr_q != '0 && ptr_q != count_q) begin
            ptr_d = ptr_q;
            raddr = Aw'(ptr_q);
            rd_vld_d = 1'b1;
            state_d = SCopy;
          end else begin
            ptr_d = count_d;
            raddr = Aw'(count_d - 1'b1);
            rd_vld_d = count_d != '0;
            state_d = STrimH;
          end
        end
      end
      SCopy: begin
        // Move entry ptr_q down by pos_q.
        we = 1'b1;
        waddr = Aw'(ptr_q - pos_q);
        ptr_d = ptr_q + 1'b1;
        if (ptr_d < count_q + pos_q) begin
          raddr = Aw'(ptr_d);
          rd_vld_d = 1'b1;
        end else begin
          ptr_d = count_q;
          state_d = STrimH;
        end
      end
      STrimH: begin
        // ptr_q is the count; rdata is entry ptr_q-1. After a copy, that read is issued here first.
        if (rd_vld_q && {1'b0, rdata} > hi_sum) begin
          count_d = ptr_q - 1'b1;
          ptr_d = count_d;
          raddr = Aw'(count_d - 1'b1);
          rd_vld_d = count_d != '0;
        end else if (!rd_vld_q && ptr_q != '0 && we == 1'b0 && pos_q != '1) begin
          raddr = Aw'(ptr_q - 1'b1);
          rd_vld_d = 1'b1;
          pos_d = '1;
        end else begin
          state_d = SDone;
        end
      end
      SDone: begin
        odata_d.entry_count = 7'(count_q);
        ovalid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      back_q     <= '0;
      fwd_q      <= '0;
      tol_q      <= '0;
      dur_q      <= '1;
      count_q    <= '0;
      cur_time_q <= '0;
      cur_idx_q  <= '0;
      cur_vld_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      cur_time_q <= cur_time_d;
      cur_idx_q  <= cur_idx_d;
      cur_vld_q  <= cur_vld_d;
      rd_vld_q   <= rd_vld_d;
      ovalid_q   <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          tsft_pkg::CfgBack:     back_q <= cfg_data_i;
          tsft_pkg::CfgForward:  fwd_q  <= cfg_data_i;
          tsft_pkg::CfgTol:      tol_q  <= cfg_data_i;
          tsft_pkg::CfgDuration: dur_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    ptr_q      <= ptr_d;
    pos_q      <= pos_d;
    best_gap_q <= best_gap_d;
    best_q     <= best_d;
    best_val_q <= best_val_d;
    odata_q    <= odata_d;
  end

endmodule

[hw/rtl/tsft_checker.sv]
module tsft_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tsft_pkg::rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= 7'd64)
    else $error("entry count out of range");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == tsft_pkg::StEmpty
    |-> !out_data_o.found && !out_data_o.changed && out_data_o.entry_count == 7'd0)
    else $error("empty status with payload");

endmodule

bind timestamp_sorted_frame_table_unit tsft_checker u_tsft_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);

[bench/timestamp_sorted_frame_table_unit_tb.sv]
module timestamp_sorted_frame_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 64;
  localparam int unsigned StampBits = tsft_pkg::StampBits;
  localparam int unsigned OpBits = tsft_pkg::OpBits;
  localparam logic [StampBits-1:0] StampMax = {StampBits{1'b1}};
  localparam int unsigned CycleLimit = 1_000_000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  tsft_pkg::req_t in_data;
  tsft_pkg::rsp_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [StampBits-1:0] cfg_data;

  timestamp_sorted_frame_table_unit #(.TABLE_DEPTH(Depth)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Local copy of the table state used to predict each response.
  logic [StampBits-1:0] stamps[Depth];
  int unsigned n_held;
  logic [StampBits-1:0] cur_time;
  int unsigned cur_idx;
  bit cur_valid;
  logic [StampBits-1:0] back_win, fwd_win, tol, dur_limit;

  tsft_pkg::req_t pending_reqs[$];
  tsft_pkg::rsp_t expected_rsps[$];
  int unsigned mismatches, n_checked, cycles;
  int unsigned n_sent;
  int unsigned op_seen[8];
  bit taken;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  function automatic logic [StampBits-1:0] gap_of(logic [StampBits-1:0] a,
                                                  logic [StampBits-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned nearest_entry(logic [StampBits-1:0] t,
                                                output logic [StampBits-1:0] gap);
    int unsigned best;
    best = 0;
    gap = gap_of(stamps[0], t);
    for (int unsigned i = 1; i < n_held; i++) begin
      if (gap_of(stamps[i], t) < gap) begin
        gap = gap_of(stamps[i], t);
        best = i;
      end
    end
    return best;
  endfunction

  function automatic void seek_nearest(logic [StampBits-1:0] t, ref tsft_pkg::rsp_t r);
    logic [StampBits-1:0] gap;
    int unsigned idx;
    idx = nearest_entry(t, gap);
    r.entry_index = idx[5:0];
    r.found = 1'b1;
    if (cur_valid && cur_idx == idx) begin
      r.changed = 1'b0;
    end else begin
      r.changed = 1'b1;
      cur_idx = idx;
      cur_valid = 1'b1;
      cur_time = stamps[idx];
    end
  endfunction

  function automatic tsft_pkg::rsp_t table_response(tsft_pkg::req_t q);
    tsft_pkg::rsp_t r;
    int unsigned pos, drop, near;
    logic [StampBits-1:0] gap;
    logic [StampBits:0] sum, hi, lo_edge;
    r = '0;
    r.status = tsft_pkg::StOk;
    case (q.op)
      tsft_pkg::OpInsert: begin
        pos = 0;
        while (pos < n_held && stamps[pos] < q.time_value) pos++;
        if (pos < n_held && stamps[pos] == q.time_value) begin
          r.status = tsft_pkg::StDup;
        end else if (n_held >= Depth) begin
          r.status = tsft_pkg::StFull;
        end else begin
          for (int i = int'(n_held); i > int'(pos); i--) stamps[i] = stamps[i-1];
          stamps[pos] = q.time_value;
          n_held++;
        end
      end
      tsft_pkg::OpShow: begin
        if (n_held == 0) r.status = tsft_pkg::StEmpty;
        else seek_nearest(q.time_value, r);
      end
      tsft_pkg::OpCheck: begin
        if (n_held == 0) begin
          r.status = tsft_pkg::StEmpty;
        end else begin
          near = nearest_entry(q.time_value, gap);
          r.entry_index = near[5:0];
          r.found = (gap <= tol);
        end
      end
      tsft_pkg::OpTrim: begin
        // Bounds are kept one bit wider so that neither side wraps.
        hi = {1'b0, cur_time} + {1'b0, fwd_win};
        drop = 0;
        while (drop < n_held) begin
          lo_edge = {1'b0, stamps[drop]} + {1'b0, back_win};
          if (lo_edge < {1'b0, cur_time}) drop++;
          else break;
        end
        if (drop > 0) begin
          for (int unsigned i = 0; i < n_held - drop; i++) stamps[i] = stamps[i+drop];
          n_held -= drop;
        end
        while (n_held > 0 && {1'b0, stamps[n_held-1]} > hi) n_held--;
      end
      tsft_pkg::OpClear: n_held = 0;
      tsft_pkg::OpAdvance: begin
        if (n_held == 0) begin
          r.status = tsft_pkg::StEmpty;
        end else begin
          sum = {1'b0, cur_time} + {1'b0, q.time_value};
          cur_time = (sum > {1'b0, dur_limit}) ? '0 : sum[StampBits-1:0];
          seek_nearest(cur_time, r);
        end
      end
      default: ;
    endcase
    r.entry_count = n_held[6:0];
    return r;
  endfunction

  // Driver: bursts of requests separated by random gaps. A request stays on
  // the bus until the acceptance below marks it as taken.
  int unsigned burst_left, gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !taken) begin
      // Hold the waiting request as it is.
    end else begin
      if (in_valid) begin
        void'(pending_reqs.pop_front());
        taken = 1'b0;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: modes change now and then.
  int unsigned stall_mode, mode_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= (($urandom_range(0, 15)) < 13);
      endcase
    end
  end

  // Request acceptance feeds the predictor; the response check follows.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_rsps.push_back(table_response(in_data));
      op_seen[in_data.op]++;
      n_sent++;
      taken = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        report("response with none expected", 64'(out_data), 64'd0);
      end else begin
        tsft_pkg::rsp_t w;
        w = expected_rsps.pop_front();
        if (out_data.entry_index !== w.entry_index)
          report("entry_index", 64'(out_data.entry_index), 64'(w.entry_index));
        if (out_data.found !== w.found)
          report("found", 64'(out_data.found), 64'(w.found));
        if (out_data.changed !== w.changed)
          report("changed", 64'(out_data.changed), 64'(w.changed));
        if (out_data.status !== w.status)
          report("status", 64'(out_data.status), 64'(w.status));
        if (out_data.entry_count !== w.entry_count)
          report("entry_count", 64'(out_data.entry_count), 64'(w.entry_count));
        n_checked++;
      end
    end
  end

  function automatic tsft_pkg::req_t make_req(logic [OpBits-1:0] op, logic [StampBits-1:0] t);
    tsft_pkg::req_t q;
    q.op = op;
    q.time_value = t;
    return q;
  endfunction

  function automatic logic [StampBits-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[StampBits-1:0];
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [StampBits-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      tsft_pkg::CfgBack: back_win = val;
      tsft_pkg::CfgForward: fwd_win = val;
      tsft_pkg::CfgTol: tol = val;
      default: dur_limit = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (2 * Depth + 20) @(posedge clk);
  endtask

  // Random request mix around a small time window so that hits, ties and
  // duplicates happen often; now and then a full-range value.
  function automatic tsft_pkg::req_t rand_req(logic [StampBits-1:0] base, int unsigned span);
    int unsigned pick;
    logic [StampBits-1:0] t;
    pick = $urandom_range(0, 99);
    t = ($urandom_range(0, 9) == 0) ? rand_stamp()
                                    : base + StampBits'($urandom_range(0, span));
    if (pick < 40) return make_req(tsft_pkg::OpInsert, t);
    if (pick < 58) return make_req(tsft_pkg::OpShow, t);
    if (pick < 72) return make_req(tsft_pkg::OpCheck, t);
    if (pick < 78) return make_req(tsft_pkg::OpTrim, t);
    if (pick < 80) return make_req(tsft_pkg::OpClear, t);
    if (pick < 97) return make_req(tsft_pkg::OpAdvance, StampBits'($urandom_range(0, span / 8)));
    return make_req(OpBits'($urandom_range(6, 7)), t);
  endfunction

  initial begin
    logic [StampBits-1:0] base;
    int unsigned span;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tsft_pkg::CfgBack;
    cfg_data = '0;
    n_held = 0;
    cur_time = '0;
    cur_idx = 0;
    cur_valid = 1'b0;
    back_win = '0;
    fwd_win = '0;
    tol = '0;
    dur_limit = StampMax;
    burst_left = 0;
    gap_left = 0;
    mode_left = 0;
    stall_mode = 0;
    taken = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-table cases, extremes, duplicates, ties and unused codes.
    pending_reqs.push_back(make_req(tsft_pkg::OpShow, 48'd0));
    pending_reqs.push_back(make_req(tsft_pkg::OpCheck, StampMax));
    pending_reqs.push_back(make_req(tsft_pkg::OpAdvance, 48'd5));
    pending_reqs.push_back(make_req(tsft_pkg::OpInsert, StampMax));
    pending_reqs.push_back(make_req(tsft_pkg::OpInsert, 48'd0));
    pending_reqs.push_back(make_req(tsft_pkg::OpInsert, 48'd100));
    pending_reqs.push_back(make_req(tsft_pkg::OpInsert, 48'd100));
    pending_reqs.push_back(make_req(tsft_pkg::OpInsert, 48'd200));
    pending_reqs.push_back(make_req(tsft_pkg::OpShow, 48'd150));
    pending_reqs.push_back(make_req(tsft_pkg::OpShow, 48'd150));
    pending_reqs.push_back(make_req(tsft_pkg::OpCheck, 48'd150));
    pending_reqs.push_back(make_req(tsft_pkg::OpInsert, 48'd50));
    pending_reqs.push_back(make_req(tsft_pkg::OpShow, 48'd100));
    pending_reqs.push_back(make_req(tsft_pkg::OpAdvance, StampMax));
    pending_reqs.push_back(make_req(3'd6, 48'h5555_5555_5555));
    pending_reqs.push_back(make_req(3'd7, 48'hAAAA_AAAA_AAAA));
    pending_reqs.push_back(make_req(tsft_pkg::OpTrim, 48'd0));
    pending_reqs.push_back(make_req(tsft_pkg::OpClear, 48'd0));
    pending_reqs.push_back(make_req(tsft_pkg::OpCheck, 48'd1));
    wait_idle();

    // Fill the table to the brim, then overflow it.
    write_reg(tsft_pkg::CfgTol, 48'd3);
    for (int i = 0; i < Depth; i++)
      pending_reqs.push_back(make_req(tsft_pkg::OpInsert, StampBits'(i * 7 + 1000)));
    pending_reqs.push_back(make_req(tsft_pkg::OpInsert, 48'd5));
    pending_reqs.push_back(make_req(tsft_pkg::OpInsert, 48'd1007));
    pending_reqs.push_back(make_req(tsft_pkg::OpCheck, 48'd1010));
    pending_reqs.push_back(make_req(tsft_pkg::OpCheck, 48'd1011));
    wait_idle();

    // Random phases, each with its own register setting and time window.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(tsft_pkg::CfgBack, 48'd0); write_reg(tsft_pkg::CfgForward, 48'd0);
          write_reg(tsft_pkg::CfgTol, 48'd0); write_reg(tsft_pkg::CfgDuration, StampMax);
        end
        1: begin
          write_reg(tsft_pkg::CfgBack, StampMax); write_reg(tsft_pkg::CfgForward, StampMax);
          write_reg(tsft_pkg::CfgTol, StampMax);
        end
        default: begin
          write_reg(tsft_pkg::CfgBack, StampBits'($urandom_range(0, 3000)));
          write_reg(tsft_pkg::CfgForward, StampBits'($urandom_range(0, 3000)));
          write_reg(tsft_pkg::CfgTol, StampBits'($urandom_range(0, 200)));
          write_reg(tsft_pkg::CfgDuration, (phase == 7) ? rand_stamp()
                                           : StampBits'($urandom_range(500, 6000)));
        end
      endcase
      base = (phase == 3) ? StampMax - 48'd4000 : StampBits'($urandom_range(0, 2000));
      span = $urandom_range(300, 4000);
      for (int k = 0; k < 100; k++) pending_reqs.push_back(rand_req(base, span));
      wait_idle();
    end

    $display("%0d requests sent, %0d responses checked", n_sent, n_checked);
    $display("ops: ins %0d show %0d chk %0d trim %0d clr %0d adv %0d unused %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
             op_seen[6] + op_seen[7]);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
